// ----- sv/midi_track_note_extractor_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the MIDI track note extractor
// Implication checks, sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH
`define MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTE_ASSERT_IMP(label, ante, cons, msg)
`define MTE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/mte_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track note extractor package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int PITCHES_DEF  = 128;
  localparam int ENTRY_W      = 39;
  localparam logic [30:0] TICK_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] RES_NOTE  = 2'd0;
  localparam logic [1:0] RES_TEMPO = 2'd1;
  localparam logic [1:0] RES_DONE  = 2'd2;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_POLY     = 4'hA;
  localparam logic [3:0] HI_CTRL     = 4'hB;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_CHPRESS  = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_NOTE_PITCH, PH_NOTE_VEL, PH_META_TYPE,
    PH_META_LEN, PH_SYSEX_LEN, PH_SKIP, PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_NOTE_CHK, S_SCAN_RD, S_SCAN_CHK, S_EMIT
  } state_t;

  typedef struct packed {
    phase_t      phase;
    logic [27:0] vlq_value;
    logic [2:0]  vlq_count;
    logic [30:0] tick_now;
    logic [7:0]  running_status;
    logic [7:0]  event_status;
    logic [6:0]  first_data;
    logic [27:0] skip_remaining;
    logic [7:0]  meta_type;
    logic [23:0] tempo_shift;
    logic [1:0]  tempo_bytes;
  } pst_t;

  typedef struct packed {
    logic        valid;
    logic        on;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [30:0] tick;
  } note_req_t;

endpackage

// ----- sv/midi_track_note_extractor.sv -----
// ----------------------------------------------------------------------------
// MIDI track note extractor
// Parses track body bytes into note records, a tempo report and flush output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is a track byte (kind 0) or a
// flush step (kind 1). Output channel (out_valid/out_ready): at most one
// result beat per input beat: note record, tempo found or flush done.
// A track byte is taken in the accepting cycle; a note-off adds S_NOTE_CHK
// (read of the held note memory, then the write back), and a result is then
// loaded in S_EMIT. A flush step walks entries from its pointer (up to
// CHANNELS * PITCHES), each in S_SCAN_RD then S_SCAN_CHK since the read data
// is registered, then loads the result in S_EMIT.
// After reset the block clears all CHANNELS * PITCHES entries of the held
// note memory, one entry per cycle, with in_ready low.
// The result sits in an output register; the next beat is accepted while it
// waits. If a new result is ready while the receiver still stalls, the block
// holds it and keeps in_ready low until the output register frees.
// ----------------------------------------------------------------------------
`include "midi_track_note_extractor_assert.svh"

module midi_track_note_extractor #(
  parameter int CHANNELS = mte_pkg::CHANNELS_DEF,
  parameter int PITCHES  = mte_pkg::PITCHES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        last_in_track,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [3:0]  channel,
  output logic [6:0]  pitch,
  output logic [30:0] start_tick,
  output logic [30:0] stop_tick,
  output logic [6:0]  velocity,
  output logic [23:0] tempo_us
);

  localparam int TOTAL  = CHANNELS * PITCHES;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  mte_pkg::state_t    state, state_next;
  mte_pkg::note_req_t note_req, req;
  logic               tempo_hit;
  logic [23:0]        tempo_val;
  logic [30:0]        track_end_tick;
  logic               accept, step;

  logic                        we;
  logic [ADDR_W-1:0]           waddr, raddr, req_addr, scan_addr;
  logic [mte_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [ADDR_W-1:0]           clr_cnt;
  logic [3:0]                  scan_ch;
  logic [6:0]                  scan_p;
  logic                        scan_last;

  logic [1:0]  res_kind;
  logic [3:0]  res_ch;
  logic [6:0]  res_p, res_vel;
  logic [30:0] res_start, res_stop;
  logic [23:0] res_tempo;
  logic        load_res, load_out, clr_ptr, adv_ptr;
  logic [1:0]  nres_kind;
  logic [3:0]  nres_ch;
  logic [6:0]  nres_p, nres_vel;
  logic [30:0] nres_start, nres_stop;
  logic [23:0] nres_tempo;

  assign accept = in_valid && in_ready;
  assign step = accept && !kind;
  assign in_ready = (state == mte_pkg::S_IDLE);

  mte_parser #(.CHANNELS(CHANNELS), .PITCHES(PITCHES)) u_parser (
    .clk, .rst, .step, .data_byte, .last_in_track,
    .note_req, .tempo_hit, .tempo_val, .track_end_tick
  );

  mte_note_mem #(.DEPTH(TOTAL), .ADDR_W(ADDR_W)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign req_addr  = ADDR_W'(32'(note_req.channel) * PITCHES + 32'(note_req.pitch));
  assign scan_addr = ADDR_W'(32'(scan_ch) * PITCHES + 32'(scan_p));
  assign scan_last = (32'(scan_ch) == CHANNELS - 1) && (32'(scan_p) == PITCHES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mte_pkg::S_CLEAR;
      clr_cnt <= '0;
      scan_ch <= 4'd0;
      scan_p <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mte_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (clr_ptr) begin
        scan_ch <= 4'd0;
        scan_p <= 7'd0;
      end else if (adv_ptr) begin
        if (32'(scan_p) == PITCHES - 1) begin
          scan_p <= 7'd0;
          scan_ch <= scan_ch + 4'd1;
        end else begin
          scan_p <= scan_p + 7'd1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && note_req.valid) begin
      req <= note_req;
    end
    if (load_res) begin
      res_kind <= nres_kind;
      res_ch <= nres_ch;
      res_p <= nres_p;
      res_start <= nres_start;
      res_stop <= nres_stop;
      res_vel <= nres_vel;
      res_tempo <= nres_tempo;
    end
    if (load_out) begin
      result_kind <= res_kind;
      channel <= res_ch;
      pitch <= res_p;
      start_tick <= res_start;
      stop_tick <= res_stop;
      velocity <= res_vel;
      tempo_us <= res_tempo;
    end
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = req_addr;
    wdata = '0;
    raddr = req_addr;
    load_res = 1'b0;
    load_out = 1'b0;
    clr_ptr = 1'b0;
    adv_ptr = 1'b0;
    nres_kind = mte_pkg::RES_NOTE;
    nres_ch = 4'd0;
    nres_p = 7'd0;
    nres_start = 31'd0;
    nres_stop = 31'd0;
    nres_vel = 7'd0;
    nres_tempo = 24'd0;
    unique case (state)
      mte_pkg::S_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
        if (32'(clr_cnt) == TOTAL - 1) begin
          state_next = mte_pkg::S_IDLE;
        end
      end
      mte_pkg::S_IDLE: begin
        if (accept && kind) begin
          state_next = mte_pkg::S_SCAN_RD;
        end else if (step && note_req.valid && note_req.on) begin
          we = 1'b1;
          wdata = {1'b1, note_req.tick, note_req.velocity};
        end else if (step && note_req.valid) begin
          state_next = mte_pkg::S_NOTE_CHK;
        end else if (step && tempo_hit) begin
          load_res = 1'b1;
          nres_kind = mte_pkg::RES_TEMPO;
          nres_tempo = tempo_val;
          state_next = mte_pkg::S_EMIT;
        end
      end
      mte_pkg::S_NOTE_CHK: begin
        waddr = ADDR_W'(32'(req.channel) * PITCHES + 32'(req.pitch));
        if (rdata[mte_pkg::ENTRY_W-1]) begin
          we = 1'b1;
          load_res = 1'b1;
          nres_ch = req.channel;
          nres_p = req.pitch;
          nres_start = rdata[37:7];
          nres_stop = req.tick;
          nres_vel = rdata[6:0];
          state_next = mte_pkg::S_EMIT;
        end else begin
          state_next = mte_pkg::S_IDLE;
        end
      end
      mte_pkg::S_SCAN_RD: begin
        raddr = scan_addr;
        state_next = mte_pkg::S_SCAN_CHK;
      end
      mte_pkg::S_SCAN_CHK: begin
        waddr = scan_addr;
        if (rdata[mte_pkg::ENTRY_W-1]) begin
          we = 1'b1;
          load_res = 1'b1;
          nres_ch = scan_ch;
          nres_p = scan_p;
          nres_start = rdata[37:7];
          nres_stop = track_end_tick;
          nres_vel = rdata[6:0];
          state_next = mte_pkg::S_EMIT;
        end else if (scan_last) begin
          clr_ptr = 1'b1;
          load_res = 1'b1;
          nres_kind = mte_pkg::RES_DONE;
          state_next = mte_pkg::S_EMIT;
        end else begin
          adv_ptr = 1'b1;
          state_next = mte_pkg::S_SCAN_RD;
        end
      end
      mte_pkg::S_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = mte_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mte_pkg::S_IDLE;
      end
    endcase
  end

  `MTE_ASSERT_IMP(a_no_accept_clear, state == mte_pkg::S_CLEAR, !in_ready, "accept during clear")
  `MTE_ASSERT_IMP(a_kind_legal, out_valid, result_kind != 2'd3, "bad result kind")
  `MTE_ASSERT_IMP(a_done_zero, out_valid && result_kind == mte_pkg::RES_DONE, start_tick == 31'd0 && channel == 4'd0, "flush done not clean")
  `MTE_ASSERT_NXT(a_flush_scan, accept && kind, state == mte_pkg::S_SCAN_RD, "flush did not scan")

endmodule

// ----- sv/mte_note_mem.sv -----
// ----------------------------------------------------------------------------
// Held-note memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mte_note_mem #(
  parameter int DEPTH  = mte_pkg::CHANNELS_DEF * mte_pkg::PITCHES_DEF,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [mte_pkg::ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [mte_pkg::ENTRY_W-1:0] rdata
);

  logic [mte_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mte_parser.sv -----
// ----------------------------------------------------------------------------
// Track byte parser
// Delta times, running status, event lengths, tempo meta and note events.
// ----------------------------------------------------------------------------
module mte_parser #(
  parameter int CHANNELS = mte_pkg::CHANNELS_DEF,
  parameter int PITCHES  = mte_pkg::PITCHES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_in_track,
  output mte_pkg::note_req_t note_req,
  output logic               tempo_hit,
  output logic [23:0]        tempo_val,
  output logic [30:0]        track_end_tick
);

  mte_pkg::pst_t st, st_next;
  logic          tempo_found;

  function automatic mte_pkg::pst_t start_skip(mte_pkg::pst_t s, logic [27:0] len);
    mte_pkg::pst_t r;
    r = s;
    r.skip_remaining = len;
    r.phase = (len == 28'd0) ? mte_pkg::PH_DELTA : mte_pkg::PH_SKIP;
    return r;
  endfunction

  function automatic mte_pkg::pst_t enter_status(mte_pkg::pst_t s, logic [7:0] sb);
    mte_pkg::pst_t r;
    r = s;
    r.event_status = sb;
    r.meta_type = 8'd0;
    r.tempo_bytes = 2'd0;
    r.tempo_shift = 24'd0;
    if (sb[7:4] == mte_pkg::HI_NOTE_OFF || sb[7:4] == mte_pkg::HI_NOTE_ON) begin
      r.phase = mte_pkg::PH_NOTE_PITCH;
    end else if (sb[7:4] == mte_pkg::HI_POLY || sb[7:4] == mte_pkg::HI_CTRL
                 || sb[7:4] == mte_pkg::HI_BEND) begin
      r = start_skip(r, 28'd2);
    end else if (sb[7:4] == mte_pkg::HI_PROG || sb[7:4] == mte_pkg::HI_CHPRESS) begin
      r = start_skip(r, 28'd1);
    end else if (sb == mte_pkg::ST_META) begin
      r.phase = mte_pkg::PH_META_TYPE;
    end else if (sb == mte_pkg::ST_SYSEX || sb == mte_pkg::ST_ESCAPE) begin
      r.vlq_value = 28'd0;
      r.vlq_count = 3'd0;
      r.phase = mte_pkg::PH_SYSEX_LEN;
    end else begin
      r.phase = mte_pkg::PH_STOP;
    end
    return r;
  endfunction

  logic [31:0] tick_sum;
  logic [27:0] vlq_new;
  logic [2:0]  cnt_new;
  logic        vlq_done;
  logic        is_data;
  logic [30:0] tick_after;

  always_comb begin
    st_next = st;
    note_req = '0;
    tempo_hit = 1'b0;
    is_data = 1'b0;
    if (st.phase == mte_pkg::PH_STATUS) begin
      if (data_byte[7]) begin
        st_next.running_status = data_byte;
        st_next = enter_status(st_next, data_byte);
      end else begin
        st_next = enter_status(st_next, st.running_status);
        is_data = (st_next.phase != mte_pkg::PH_STOP);
      end
    end else begin
      is_data = 1'b1;
    end
    vlq_new = {st_next.vlq_value[20:0], data_byte[6:0]};
    cnt_new = st_next.vlq_count + 3'd1;
    vlq_done = !data_byte[7] || (cnt_new >= 3'd4);
    tick_sum = {1'b0, st_next.tick_now} + {4'd0, vlq_new};
    if (is_data) begin
      unique case (st_next.phase)
        mte_pkg::PH_DELTA: begin
          st_next.vlq_value = vlq_new;
          st_next.vlq_count = cnt_new;
          if (vlq_done) begin
            st_next.vlq_count = 3'd0;
            st_next.tick_now = (tick_sum > {1'b0, mte_pkg::TICK_MAX})
                               ? mte_pkg::TICK_MAX : tick_sum[30:0];
            st_next.vlq_value = 28'd0;
            st_next.phase = mte_pkg::PH_STATUS;
          end
        end
        mte_pkg::PH_NOTE_PITCH: begin
          st_next.first_data = data_byte[6:0];
          st_next.phase = mte_pkg::PH_NOTE_VEL;
        end
        mte_pkg::PH_NOTE_VEL: begin
          st_next.phase = mte_pkg::PH_DELTA;
          note_req.channel = st_next.event_status[3:0];
          note_req.pitch = st_next.first_data;
          note_req.velocity = data_byte[6:0];
          note_req.tick = st_next.tick_now;
          note_req.on = (st_next.event_status[7:4] == mte_pkg::HI_NOTE_ON)
                        && (data_byte[6:0] != 7'd0);
          note_req.valid = (32'(st_next.event_status[3:0]) < CHANNELS)
                           && (32'(st_next.first_data) < PITCHES);
        end
        mte_pkg::PH_META_TYPE: begin
          st_next.meta_type = data_byte;
          st_next.vlq_value = 28'd0;
          st_next.vlq_count = 3'd0;
          st_next.phase = mte_pkg::PH_META_LEN;
        end
        mte_pkg::PH_META_LEN, mte_pkg::PH_SYSEX_LEN: begin
          st_next.vlq_value = vlq_new;
          st_next.vlq_count = cnt_new;
          if (vlq_done) begin
            st_next.vlq_count = 3'd0;
            if (st_next.phase != mte_pkg::PH_META_LEN
                || !(st_next.meta_type == mte_pkg::META_TEMPO && vlq_new == 28'd3)) begin
              st_next.meta_type = 8'd0;
            end
            st_next.tempo_bytes = 2'd0;
            st_next.tempo_shift = 24'd0;
            st_next = start_skip(st_next, vlq_new);
            st_next.vlq_value = 28'd0;
          end
        end
        mte_pkg::PH_SKIP: begin
          if (st_next.meta_type == mte_pkg::META_TEMPO) begin
            st_next.tempo_shift = {st_next.tempo_shift[15:0], data_byte};
            st_next.tempo_bytes = st_next.tempo_bytes + 2'd1;
          end
          if (st_next.skip_remaining != 28'd0) begin
            st_next.skip_remaining = st_next.skip_remaining - 28'd1;
          end
          if (st_next.skip_remaining == 28'd0) begin
            st_next.phase = mte_pkg::PH_DELTA;
            tempo_hit = (st_next.meta_type == mte_pkg::META_TEMPO)
                        && (st_next.tempo_bytes == 2'd3)
                        && (st_next.tempo_shift != 24'd0) && !tempo_found;
          end
        end
        default: begin
        end
      endcase
    end
    tempo_val = st_next.tempo_shift;
    tick_after = st_next.tick_now;
    if (last_in_track) begin
      st_next = '0;
      st_next.phase = mte_pkg::PH_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      tempo_found <= 1'b0;
      track_end_tick <= 31'd0;
    end else if (step) begin
      st <= st_next;
      if (tempo_hit) begin
        tempo_found <= 1'b1;
      end
      if (last_in_track) begin
        track_end_tick <= tick_after;
      end
    end
  end

endmodule
